FILE: src/heapsort_duplicate_check_assert.svh
// Assertion helpers for the heapsort duplicate check block.
// Each check is sampled on the rising clock edge and is off while reset is low.
// Defining SYNTH turns every check into nothing.
`ifndef HEAPSORT_DUPLICATE_CHECK_ASSERT_SVH
`define HEAPSORT_DUPLICATE_CHECK_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define HDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hdc check failed");

// Next-cycle implication.
`define HDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hdc check failed");

`else

`define HDC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/hdc_pkg.sv
`default_nettype none

package hdc_pkg;

  localparam int ORD_W = 32;

  // One request on the input channel
  typedef struct packed {
    logic [ORD_W-1:0] ordinal_value;
    logic             set_last;
  } in_item_t;

  // One result on the output channel
  typedef struct packed {
    logic [ORD_W-1:0] sorted_value;
    logic             equals_previous;
    logic             any_duplicate;
    logic             overflowed;
    logic             result_last;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // store accepted request
    logic bld_init;  // i = n/2, clear emit state
    logic bld_rd;    // read entry i-1
    logic bld_go;    // start sift of entry i-1 over n entries
    logic sf_left;   // read left child, or park value if no child
    logic sf_right;  // save left value, read right child
    logic sf_cmp;    // compare, move bigger child up or park value
    logic ext_init;  // i = n-1
    logic ext_rd0;   // read root
    logic ext_rdi;   // save root, read entry i
    logic ext_go;    // root to entry i, sift old entry i from root
    logic i_dec;     // i = i-1
    logic emit_rd;   // read entry k
    logic emit_ld;   // load output register with entry k
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic n_small;    // fewer than two stored values
    logic left_ok;    // left child lies inside the heap
    logic stop;       // sifted value is not below its bigger child
    logic i_one;      // loop index is one
    logic emit_last;  // entry k is the last of the set
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

`default_nettype wire

FILE: src/hdc_datapath.sv
`default_nettype none

module hdc_datapath
  import hdc_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cmd_t      cmd_i,
  output sts_t           sts_o,
  input  wire in_item_t  in_item_i,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  output out_item_t      out_item_o
);

  `include "heapsort_duplicate_check_assert.svh"

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int XW = AW + 2;

  // Value store, one write and one registered read per cycle
  logic [ORD_W-1:0] mem [2**AW];
  logic [ORD_W-1:0] rdata_r;
  logic [AW-1:0]    raddr;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [ORD_W-1:0] wdata;

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [AW-1:0]    i_r, i_nxt;
  logic [AW-1:0]    node_r, node_nxt;
  logic [CW-1:0]    size_r, size_nxt;
  logic [ORD_W-1:0] v_r, v_nxt;
  logic [ORD_W-1:0] lval_r, lval_nxt;
  logic             hasr_r, hasr_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic [ORD_W-1:0] prev_r, prev_nxt;
  logic             dup_r, dup_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic [XW-1:0]    left;
  logic [XW-1:0]    right;
  logic             big_gt;
  logic [ORD_W-1:0] big_val;
  logic [AW-1:0]    big_idx;
  logic             stop;
  logic             emit_last;
  logic             eq;
  logic             cnt_full;

  // Heap navigation and child compare
  always_comb begin
    left      = {1'b0, node_r, 1'b1};
    right     = left + XW'(1);
    big_gt    = hasr_r && (rdata_r > lval_r);
    big_val   = big_gt ? rdata_r : lval_r;
    big_idx   = big_gt ? right[AW-1:0] : left[AW-1:0];
    stop      = (v_r >= big_val);
    emit_last = ((CW'(k_r) + CW'(1)) == cnt_r);
    eq        = (k_r != '0) && (rdata_r == prev_r);
    cnt_full  = (cnt_r == CW'(MAX_ITEMS));
  end

  // Status to controller
  always_comb begin
    sts_o.n_small   = (cnt_r < CW'(2));
    sts_o.left_ok   = (left < XW'(size_r));
    sts_o.stop      = stop;
    sts_o.i_one     = (i_r == AW'(1));
    sts_o.emit_last = emit_last;
    sts_o.out_free  = !out_valid_r || out_ready_i;
  end

  // Read address select
  always_comb begin
    raddr = '0;
    if (cmd_i.bld_rd) begin
      raddr = i_r - AW'(1);
    end else if (cmd_i.sf_left) begin
      raddr = left[AW-1:0];
    end else if (cmd_i.sf_right) begin
      raddr = right[AW-1:0];
    end else if (cmd_i.ext_rd0) begin
      raddr = '0;
    end else if (cmd_i.ext_rdi) begin
      raddr = i_r;
    end else if (cmd_i.emit_rd) begin
      raddr = k_r;
    end
  end

  // Write port select
  always_comb begin
    we    = 1'b0;
    waddr = node_r;
    wdata = v_r;
    if (cmd_i.load && !cnt_full) begin
      we    = 1'b1;
      waddr = cnt_r[AW-1:0];
      wdata = in_item_i.ordinal_value;
    end else if (cmd_i.sf_left && !sts_o.left_ok) begin
      we = 1'b1;
    end else if (cmd_i.sf_cmp) begin
      we    = 1'b1;
      wdata = stop ? v_r : big_val;
    end else if (cmd_i.ext_go) begin
      we    = 1'b1;
      waddr = i_r;
      wdata = lval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Next-state logic of the datapath registers
  always_comb begin
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    node_nxt      = node_r;
    size_nxt      = size_r;
    v_nxt         = v_r;
    lval_nxt      = lval_r;
    hasr_nxt      = hasr_r;
    k_nxt         = k_r;
    prev_nxt      = prev_r;
    dup_nxt       = dup_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready_i;

    if (cmd_i.load) begin
      if (cnt_full) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
    if (cmd_i.bld_init) begin
      i_nxt   = AW'(cnt_r >> 1);
      k_nxt   = '0;
      dup_nxt = 1'b0;
    end
    if (cmd_i.bld_go) begin
      v_nxt    = rdata_r;
      node_nxt = i_r - AW'(1);
      size_nxt = cnt_r;
    end
    if (cmd_i.sf_right) begin
      lval_nxt = rdata_r;
      hasr_nxt = (right < XW'(size_r));
    end
    if (cmd_i.sf_cmp && !stop) begin
      node_nxt = big_idx;
    end
    if (cmd_i.ext_init) begin
      i_nxt = AW'(cnt_r - CW'(1));
    end
    if (cmd_i.ext_rdi) begin
      lval_nxt = rdata_r;
    end
    if (cmd_i.ext_go) begin
      v_nxt    = rdata_r;
      node_nxt = '0;
      size_nxt = CW'(i_r);
    end
    if (cmd_i.i_dec) begin
      i_nxt = i_r - AW'(1);
    end
    if (cmd_i.emit_ld) begin
      out_nxt.sorted_value    = rdata_r;
      out_nxt.equals_previous = eq;
      out_nxt.any_duplicate   = emit_last && (dup_r || eq);
      out_nxt.overflowed      = ovf_r;
      out_nxt.result_last     = emit_last;
      out_valid_nxt           = 1'b1;
      prev_nxt                = rdata_r;
      dup_nxt                 = dup_r || eq;
      k_nxt                   = k_r + AW'(1);
      if (emit_last) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    node_r <= node_nxt;
    size_r <= size_nxt;
    v_r    <= v_nxt;
    lval_r <= lval_nxt;
    hasr_r <= hasr_nxt;
    k_r    <= k_nxt;
    prev_r <= prev_nxt;
    dup_r  <= dup_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid_o = out_valid_r;
  assign out_item_o  = out_r;

  // Checks
  `HDC_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_ITEMS))
  `HDC_ASSERT_IMPL(a_ovf_full, clk, rst_n, ovf_r, cnt_full)
  `HDC_ASSERT_NEXT(a_sift_down, clk, rst_n, cmd_i.sf_cmp && !stop, node_r > $past(node_r))

endmodule

`default_nettype wire

FILE: src/hdc_ctrl.sv
`default_nettype none

module hdc_ctrl
  import hdc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid_i,
  input  wire logic in_last_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_BRD   = 4'd2;
  localparam logic [3:0] ST_BGO   = 4'd3;
  localparam logic [3:0] ST_SFL   = 4'd4;
  localparam logic [3:0] ST_SFR   = 4'd5;
  localparam logic [3:0] ST_SFC   = 4'd6;
  localparam logic [3:0] ST_NXT   = 4'd7;
  localparam logic [3:0] ST_XR0   = 4'd8;
  localparam logic [3:0] ST_XRI   = 4'd9;
  localparam logic [3:0] ST_XGO   = 4'd10;
  localparam logic [3:0] ST_ERD   = 4'd11;
  localparam logic [3:0] ST_ELD   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       extract_r, extract_nxt;  // 0: heap build, 1: root extraction

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    extract_nxt = extract_r;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        cmd_o.bld_init = 1'b1;
        extract_nxt    = 1'b0;
        state_nxt      = sts_i.n_small ? ST_ERD : ST_BRD;
      end
      ST_BRD: begin
        cmd_o.bld_rd = 1'b1;
        state_nxt    = ST_BGO;
      end
      ST_BGO: begin
        cmd_o.bld_go = 1'b1;
        state_nxt    = ST_SFL;
      end
      ST_SFL: begin
        cmd_o.sf_left = 1'b1;
        state_nxt     = sts_i.left_ok ? ST_SFR : ST_NXT;
      end
      ST_SFR: begin
        cmd_o.sf_right = 1'b1;
        state_nxt      = ST_SFC;
      end
      ST_SFC: begin
        cmd_o.sf_cmp = 1'b1;
        state_nxt    = sts_i.stop ? ST_NXT : ST_SFL;
      end
      ST_NXT: begin
        if (!extract_r) begin
          if (sts_i.i_one) begin
            cmd_o.ext_init = 1'b1;
            extract_nxt    = 1'b1;
            state_nxt      = ST_XR0;
          end else begin
            cmd_o.i_dec = 1'b1;
            state_nxt   = ST_BRD;
          end
        end else begin
          if (sts_i.i_one) begin
            state_nxt = ST_ERD;
          end else begin
            cmd_o.i_dec = 1'b1;
            state_nxt   = ST_XR0;
          end
        end
      end
      ST_XR0: begin
        cmd_o.ext_rd0 = 1'b1;
        state_nxt     = ST_XRI;
      end
      ST_XRI: begin
        cmd_o.ext_rdi = 1'b1;
        state_nxt     = ST_XGO;
      end
      ST_XGO: begin
        cmd_o.ext_go = 1'b1;
        state_nxt    = ST_SFL;
      end
      ST_ERD: begin
        cmd_o.emit_rd = 1'b1;
        state_nxt     = ST_ELD;
      end
      ST_ELD: begin
        // keep the read address so the data holds while stalled
        cmd_o.emit_rd = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          state_nxt     = sts_i.emit_last ? ST_LOAD : ST_ERD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      extract_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      extract_r <= extract_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/heapsort_duplicate_check.sv
`default_nettype none

// Collects up to MAX_ITEMS 32-bit ordinals, one request per cycle while the
// block is loading, and on the request marked set_last sorts them ascending
// by in-place heapsort, then streams them out with equal-to-previous flags;
// the last result also carries the any-duplicate flag. Requests past capacity
// are dropped and flagged as overflowed. The store is a single memory with one
// write and one registered read per cycle, so each sift level is done as a
// left read, a right read, then a compare and write. A set takes n/2 build
// steps and n-1 extraction steps. Results are emitted one at a time: each is
// read from the store and then loaded into the output register, waiting while
// that register is not free. No new set is accepted until the last result of
// the current set has been loaded into the output register.
module heapsort_duplicate_check
  import hdc_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);

  cmd_t cmd;
  sts_t sts;

  hdc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_valid),
    .in_last_i  (in_item.set_last),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hdc_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item),
    .out_ready_i (out_ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

endmodule

`default_nettype wire
